@@ hw/rtl/bcr_pkg.sv @@
// ----------------------------------------------------------------------------
// Button click recognizer package
// Shared codes, defaults and the event bundle passed from front to back.
// ----------------------------------------------------------------------------
package bcr_pkg;

	// Default width of the internal millisecond time base.
	localparam int TIME_BITS_DEF = 32;

	// Widths of the port fields.
	localparam int EVT_TIME_W  = 32;
	localparam int CFG_W       = 16;
	localparam int MAX_EVENTS  = 3;
	localparam int QUEUE_DEPTH = 2;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] LONG_HOLD_RST = 16'd1000;
	localparam logic [CFG_W-1:0] CLICK_WIN_RST = 16'd300;

	// Configuration register indexes.
	typedef enum logic {
		REG_LONG_HOLD = 1'b0,
		REG_CLICK_WIN = 1'b1
	} cfg_reg_t;

	// Input opcodes. The fourth code is unused and ignored.
	typedef enum logic [1:0] {
		OP_LEVEL  = 2'd0,
		OP_TICK   = 2'd1,
		OP_CANCEL = 2'd2
	} opcode_t;

	// Output event kinds.
	typedef enum logic [2:0] {
		EVT_PRESSED    = 3'd0,
		EVT_RELEASED   = 3'd1,
		EVT_SINGLE     = 3'd2,
		EVT_DOUBLE     = 3'd3,
		EVT_HOLD_START = 3'd4,
		EVT_HOLD_END   = 3'd5,
		EVT_CANCELLED  = 3'd6
	} evt_kind_t;

	// All events caused by one input item, first event in slot 0.
	typedef struct packed {
		logic [1:0]                            cnt;
		evt_kind_t [MAX_EVENTS-1:0]            kind;
		logic [MAX_EVENTS-1:0][EVT_TIME_W-1:0] stamp;
	} evt_bundle_t;

endpackage

@@ hw/rtl/button_click_recognizer_top.sv @@
// ----------------------------------------------------------------------------
// Button click recognizer
// Turns timestamped button samples, ticks and cancels into click events.
// ----------------------------------------------------------------------------
// Each request on the input stream is a level sample, a time tick or a cancel
// with a millisecond timestamp; the block answers with zero to three events
// (pressed, released, single click, double click, long hold start, long hold
// end, cancelled), and the last event caused by one request carries tlast.
// The front end takes a request in every cycle while its two-entry bundle
// queue has room, updates the button state in that same cycle, and files all
// events of the request as one bundle. The back end drains one event per
// cycle while the output is ready; a request with no event files no bundle,
// and the output channel sets the sustained rate. The first event of a
// request passes through the bundle queue and the back end's bundle register
// before it is offered on the output. Configuration writes take effect at the
// clock edge that samples the write enable and should only be made while no
// events are in flight.
module button_click_recognizer_top #(
	parameter int TIME_BITS = bcr_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: index 0 long hold limit, index 1 click window (ms).
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	// Input requests.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [0] button_level, [32:1] now_time, rest zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
	// Output events.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] event_time
	output logic [2:0]  m_axis_tuser,  // [2:0] event_kind
	output logic        m_axis_tlast   // last_of_run
);

	logic                 push, full, q_valid, q_pop;
	bcr_pkg::evt_bundle_t push_bundle, q_head;

	// The front end classifies each request and updates the button state.
	bcr_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_opcode  (s_axis_tuser),
		.in_level   (s_axis_tdata[0]),
		.in_time    (s_axis_tdata[32:1]),
		.push       (push),
		.push_bundle(push_bundle),
		.queue_full (full)
	);

	// The queue lets the front end keep taking requests while events drain.
	bcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_bundle(push_bundle),
		.full       (full),
		.pop        (q_pop),
		.not_empty  (q_valid),
		.head       (q_head)
	);

	// The back end serializes a bundle onto the output stream.
	bcr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_kind (m_axis_tuser),
		.out_time (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

@@ hw/rtl/bcr_front.sv @@
// ----------------------------------------------------------------------------
// Button click recognizer front end
// Accepts input items, keeps the button state and builds the event bundle.
// ----------------------------------------------------------------------------
module bcr_front #(
	parameter int TIME_BITS = bcr_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bcr_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  in_opcode,
	input  logic                        in_level,
	input  logic [bcr_pkg::EVT_TIME_W-1:0] in_time,
	output logic                        push,
	output bcr_pkg::evt_bundle_t        push_bundle,
	input  logic                        queue_full
);

	logic [bcr_pkg::CFG_W-1:0] hold_limit_q, click_win_q;
	logic                      pressed_q, hold_q, waiting_q, skip_q;
	logic [TIME_BITS-1:0]      press_time_q, rel_time_q;

	logic                      pressed_d, hold_d, waiting_d, skip_d;
	logic [TIME_BITS-1:0]      press_time_d, rel_time_d;
	bcr_pkg::evt_bundle_t      bnd;

	logic [TIME_BITS-1:0]      now_t, since_press, since_rel, limit_ext, win_ext;
	logic                      hold_due, accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	assign now_t       = TIME_BITS'(in_time);
	assign limit_ext   = TIME_BITS'(hold_limit_q);
	assign win_ext     = TIME_BITS'(click_win_q);
	// Elapsed time is zero when the timestamp has gone backwards.
	assign since_press = (now_t >= press_time_q) ? now_t - press_time_q : '0;
	assign since_rel   = (now_t >= rel_time_q) ? now_t - rel_time_q : '0;
	assign hold_due    = pressed_q && !hold_q && (since_press >= limit_ext);

	always_comb begin
		logic [bcr_pkg::EVT_TIME_W-1:0] now_o, rel_o;
		now_o        = bcr_pkg::EVT_TIME_W'(now_t);
		rel_o        = bcr_pkg::EVT_TIME_W'(rel_time_q);
		pressed_d    = pressed_q;
		hold_d       = hold_q;
		waiting_d    = waiting_q;
		skip_d       = skip_q;
		press_time_d = press_time_q;
		rel_time_d   = rel_time_q;
		bnd          = '0;
		for (int i = 0; i < bcr_pkg::MAX_EVENTS; i++) begin
			bnd.stamp[i] = now_o;
		end
		unique case (in_opcode)
			bcr_pkg::OP_LEVEL: begin
				if (in_level == pressed_q) begin
					if (in_level && hold_due) begin
						hold_d       = 1'b1;
						bnd.cnt      = 2'd1;
						bnd.kind[0]  = bcr_pkg::EVT_HOLD_START;
					end
				end else if (in_level) begin
					pressed_d    = 1'b1;
					press_time_d = now_t;
					hold_d       = 1'b0;
					bnd.cnt      = 2'd1;
					bnd.kind[0]  = bcr_pkg::EVT_PRESSED;
					if (waiting_q) begin
						waiting_d = 1'b0;
						bnd.cnt   = 2'd2;
						if (since_rel <= win_ext) begin
							skip_d      = 1'b1;
							bnd.kind[1] = bcr_pkg::EVT_DOUBLE;
						end else begin
							// A late second press reports the first click at its release.
							bnd.kind[1]  = bcr_pkg::EVT_SINGLE;
							bnd.stamp[1] = rel_o;
						end
					end
				end else begin
					pressed_d = 1'b0;
					if (hold_due || hold_q) begin
						if (hold_due) begin
							bnd.cnt     = 2'd3;
							bnd.kind[0] = bcr_pkg::EVT_HOLD_START;
							bnd.kind[1] = bcr_pkg::EVT_RELEASED;
							bnd.kind[2] = bcr_pkg::EVT_HOLD_END;
						end else begin
							bnd.cnt     = 2'd2;
							bnd.kind[0] = bcr_pkg::EVT_RELEASED;
							bnd.kind[1] = bcr_pkg::EVT_HOLD_END;
						end
						hold_d    = 1'b0;
						waiting_d = 1'b0;
						skip_d    = 1'b0;
					end else begin
						bnd.cnt     = 2'd1;
						bnd.kind[0] = bcr_pkg::EVT_RELEASED;
						if (skip_q) begin
							skip_d    = 1'b0;
							waiting_d = 1'b0;
						end else begin
							waiting_d  = 1'b1;
							rel_time_d = now_t;
						end
					end
				end
			end
			bcr_pkg::OP_TICK: begin
				if (pressed_q) begin
					if (hold_due) begin
						hold_d      = 1'b1;
						bnd.cnt     = 2'd1;
						bnd.kind[0] = bcr_pkg::EVT_HOLD_START;
					end
				end else if (waiting_q && (since_rel >= win_ext)) begin
					waiting_d   = 1'b0;
					bnd.cnt     = 2'd1;
					bnd.kind[0] = bcr_pkg::EVT_SINGLE;
				end
			end
			bcr_pkg::OP_CANCEL: begin
				if (pressed_q || waiting_q) begin
					bnd.cnt     = 2'd1;
					bnd.kind[0] = bcr_pkg::EVT_CANCELLED;
				end
				pressed_d    = 1'b0;
				hold_d       = 1'b0;
				waiting_d    = 1'b0;
				skip_d       = 1'b0;
				press_time_d = '0;
				rel_time_d   = '0;
			end
			default: begin
			end
		endcase
	end

	assign push        = accept && (bnd.cnt != 2'd0);
	assign push_bundle = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_limit_q <= bcr_pkg::LONG_HOLD_RST;
			click_win_q  <= bcr_pkg::CLICK_WIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcr_pkg::REG_LONG_HOLD: hold_limit_q <= cfg_wdata;
				bcr_pkg::REG_CLICK_WIN: click_win_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q    <= 1'b0;
			hold_q       <= 1'b0;
			waiting_q    <= 1'b0;
			skip_q       <= 1'b0;
			press_time_q <= '0;
			rel_time_q   <= '0;
		end else if (accept) begin
			pressed_q    <= pressed_d;
			hold_q       <= hold_d;
			waiting_q    <= waiting_d;
			skip_q       <= skip_d;
			press_time_q <= press_time_d;
			rel_time_q   <= rel_time_d;
		end
	end

endmodule

@@ hw/rtl/bcr_queue.sv @@
// ----------------------------------------------------------------------------
// Button click recognizer bundle queue
// Two-entry queue of event bundles between the front and the back end.
// ----------------------------------------------------------------------------
module bcr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bcr_pkg::evt_bundle_t push_bundle,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output bcr_pkg::evt_bundle_t head
);

	localparam int PTR_W = $clog2(bcr_pkg::QUEUE_DEPTH);

	bcr_pkg::evt_bundle_t     entry_q [bcr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]           fill_q;

	assign full      = (fill_q == (PTR_W+1)'(bcr_pkg::QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/bcr_back.sv @@
// ----------------------------------------------------------------------------
// Button click recognizer back end
// Takes one bundle at a time and sends its events out one per ready cycle.
// ----------------------------------------------------------------------------
module bcr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  bcr_pkg::evt_bundle_t           q_head,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     out_kind,
	output logic [bcr_pkg::EVT_TIME_W-1:0] out_time,
	output logic                           out_last
);

	bcr_pkg::evt_bundle_t bundle_q;
	logic                 busy_q;
	logic [1:0]           idx_q;
	logic                 last_evt, done;

	assign last_evt  = (idx_q == bundle_q.cnt - 2'd1);
	assign done      = busy_q && out_ready && last_evt;
	assign q_pop     = q_valid && (!busy_q || done);

	assign out_valid = busy_q;
	assign out_kind  = bundle_q.kind[idx_q];
	assign out_time  = bundle_q.stamp[idx_q];
	assign out_last  = last_evt;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bundle_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

@@ hw/rtl/bcr_checker.sv @@
// ----------------------------------------------------------------------------
// Button click recognizer port checker
// Watches the top level's ports and flags illegal output sequences.
// ----------------------------------------------------------------------------
module bcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A stalled event stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output event withdrawn while stalled");

	// A stalled event keeps its contents.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output event changed while stalled");

	// Clicks, hold end and cancel always close the run of their request.
	a_closing_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == bcr_pkg::EVT_SINGLE ||
			m_axis_tuser == bcr_pkg::EVT_DOUBLE ||
			m_axis_tuser == bcr_pkg::EVT_HOLD_END ||
			m_axis_tuser == bcr_pkg::EVT_CANCELLED) |-> m_axis_tlast)
		else $error("closing event without tlast");

	// A hold start that does not end its run is followed by a release.
	a_hold_then_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast &&
			m_axis_tuser == bcr_pkg::EVT_HOLD_START
			|=> !m_axis_tvalid || m_axis_tuser == bcr_pkg::EVT_RELEASED)
		else $error("hold start inside a run not followed by release");

endmodule

bind button_click_recognizer_top bcr_checker u_bcr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Button click recognizer testbench
// Drives timestamped level samples, ticks and cancels into the recognizer,
// predicts the click events of every accepted request and checks each event
// that leaves the output stream, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import bcr_pkg::*;

	localparam int CYCLE_LIMIT = 60000;
	localparam int DRAIN_LIMIT = 2000;
	localparam int PHASE_ITEMS = 22;
	localparam int PHASE_COUNT = 6;
	localparam int ROW_COUNT   = 26;

	// The fourth opcode has no name in the package; the block must ignore it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		evt_kind_t   kind;
		logic [31:0] stamp;
		bit          last;
	} click_evt_t;

	typedef struct {
		logic [1:0]  op;
		bit          lvl;
		logic [31:0] now;
		bit          typed;
		evt_kind_t   kind;
		logic [31:0] stamp;
	} stim_row_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic        cfg_index     = 1'b0;
	logic [15:0] cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;  // [0] button_level, [32:1] now_time, rest zero
	logic [1:0]  s_axis_tuser  = '0;  // [1:0] opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [31:0] event_time
	logic [2:0]  m_axis_tuser;        // [2:0] event_kind
	logic        m_axis_tlast;

	// Predicted button state and register copies.
	bit          st_pressed;
	bit          st_hold;
	bit          st_click_wait;
	bit          st_skip_release;
	logic [31:0] st_press_t;
	logic [31:0] st_release_t;
	logic [15:0] cfg_hold_limit;
	logic [15:0] cfg_click_window;

	click_evt_t  run_events[$];
	click_evt_t  pending_events[$];

	int  mismatches    = 0;
	int  requests_sent = 0;
	int  events_seen   = 0;
	int  settings_used = 0;
	int  cycles        = 0;
	bit  no_gaps       = 1'b0;
	logic [31:0] cur_time;

	stim_row_t directed_rows [ROW_COUNT] = '{
		'{OP_TICK,   1'b0, 32'd0,    1'b0, EVT_PRESSED,    32'd0},
		'{OP_LEVEL,  1'b0, 32'd5,    1'b0, EVT_PRESSED,    32'd0},
		'{OP_CANCEL, 1'b0, 32'd7,    1'b0, EVT_PRESSED,    32'd0},
		'{OP_UNUSED, 1'b1, 32'd9,    1'b0, EVT_PRESSED,    32'd0},
		'{OP_LEVEL,  1'b1, 32'd100,  1'b1, EVT_PRESSED,    32'd100},
		'{OP_LEVEL,  1'b1, 32'd200,  1'b0, EVT_PRESSED,    32'd0},
		'{OP_LEVEL,  1'b0, 32'd250,  1'b1, EVT_RELEASED,   32'd250},
		'{OP_LEVEL,  1'b1, 32'd400,  1'b0, EVT_PRESSED,    32'd0},
		'{OP_LEVEL,  1'b0, 32'd450,  1'b0, EVT_PRESSED,    32'd0},
		'{OP_LEVEL,  1'b1, 32'd600,  1'b1, EVT_PRESSED,    32'd600},
		'{OP_LEVEL,  1'b0, 32'd700,  1'b1, EVT_RELEASED,   32'd700},
		'{OP_TICK,   1'b0, 32'd900,  1'b0, EVT_PRESSED,    32'd0},
		'{OP_TICK,   1'b0, 32'd1000, 1'b1, EVT_SINGLE,     32'd1000},
		'{OP_LEVEL,  1'b1, 32'd2000, 1'b1, EVT_PRESSED,    32'd2000},
		'{OP_LEVEL,  1'b0, 32'd2100, 1'b1, EVT_RELEASED,   32'd2100},
		'{OP_LEVEL,  1'b1, 32'd2500, 1'b0, EVT_PRESSED,    32'd0},
		'{OP_TICK,   1'b0, 32'd3500, 1'b1, EVT_HOLD_START, 32'd3500},
		'{OP_LEVEL,  1'b0, 32'd3700, 1'b0, EVT_PRESSED,    32'd0},
		'{OP_LEVEL,  1'b1, 32'd4000, 1'b1, EVT_PRESSED,    32'd4000},
		'{OP_LEVEL,  1'b0, 32'd5200, 1'b0, EVT_PRESSED,    32'd0},
		'{OP_LEVEL,  1'b1, 32'd6000, 1'b1, EVT_PRESSED,    32'd6000},
		'{OP_CANCEL, 1'b0, 32'd6100, 1'b1, EVT_CANCELLED,  32'd6100},
		'{OP_LEVEL,  1'b1, 32'hFFFF_FFF0, 1'b1, EVT_PRESSED, 32'hFFFF_FFF0},
		'{OP_LEVEL,  1'b1, 32'h0000_0010, 1'b0, EVT_PRESSED, 32'd0},
		'{OP_LEVEL,  1'b0, 32'hFFFF_FFFF, 1'b0, EVT_PRESSED, 32'd0},
		'{OP_CANCEL, 1'b0, 32'hFFFF_FFFF, 1'b1, EVT_CANCELLED, 32'hFFFF_FFFF}
	};

	logic [15:0] phase_hold [PHASE_COUNT] = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1000, 16'd0};
	logic [15:0] phase_win  [PHASE_COUNT] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd300, 16'd0};

	button_click_recognizer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [31:0] elapsed_ms(logic [31:0] start, logic [31:0] now);
		return (now >= start) ? now - start : 32'd0;
	endfunction

	function automatic void note_event(evt_kind_t kind, logic [31:0] stamp);
		click_evt_t ev;
		ev.kind  = kind;
		ev.stamp = stamp;
		ev.last  = 1'b0;
		if (run_events.size() < MAX_EVENTS)
			run_events.insert(run_events.size(), ev);
	endfunction

	function automatic void check_long_hold(logic [31:0] now);
		if (!st_pressed || st_hold)
			return;
		if (elapsed_ms(st_press_t, now) < {16'd0, cfg_hold_limit})
			return;
		st_hold = 1'b1;
		note_event(EVT_HOLD_START, now);
	endfunction

	function automatic void clear_button_state();
		st_pressed      = 1'b0;
		st_hold         = 1'b0;
		st_click_wait   = 1'b0;
		st_skip_release = 1'b0;
		st_press_t      = '0;
		st_release_t    = '0;
	endfunction

	function automatic void take_level(bit lvl, logic [31:0] now);
		if (lvl == st_pressed) begin
			if (lvl)
				check_long_hold(now);
		end else if (lvl) begin
			st_pressed = 1'b1;
			st_press_t = now;
			st_hold    = 1'b0;
			note_event(EVT_PRESSED, now);
			if (st_click_wait) begin
				st_click_wait = 1'b0;
				if (elapsed_ms(st_release_t, now) <= {16'd0, cfg_click_window}) begin
					st_skip_release = 1'b1;
					note_event(EVT_DOUBLE, now);
				end else begin
					// Second press came too late: the first click stands alone.
					note_event(EVT_SINGLE, st_release_t);
				end
			end
		end else begin
			check_long_hold(now);
			st_pressed = 1'b0;
			note_event(EVT_RELEASED, now);
			if (st_hold) begin
				note_event(EVT_HOLD_END, now);
				st_hold         = 1'b0;
				st_click_wait   = 1'b0;
				st_skip_release = 1'b0;
			end else if (st_skip_release) begin
				st_skip_release = 1'b0;
				st_click_wait   = 1'b0;
			end else begin
				st_click_wait = 1'b1;
				st_release_t  = now;
			end
		end
	endfunction

	// Fills run_events with what one accepted request should produce.
	function automatic void predict_request(logic [1:0] op, bit lvl, logic [31:0] now);
		run_events.delete();
		case (op)
			OP_LEVEL: begin
				take_level(lvl, now);
			end
			OP_TICK: begin
				if (st_pressed)
					check_long_hold(now);
				else if (st_click_wait &&
						elapsed_ms(st_release_t, now) >= {16'd0, cfg_click_window}) begin
					st_click_wait = 1'b0;
					note_event(EVT_SINGLE, now);
				end
			end
			OP_CANCEL: begin
				if (st_pressed || st_click_wait)
					note_event(EVT_CANCELLED, now);
				clear_button_state();
			end
			default: begin
			end
		endcase
		if (run_events.size() > 0)
			run_events[run_events.size() - 1].last = 1'b1;
	endfunction

	function automatic void file_events();
		foreach (run_events[i])
			pending_events.insert(pending_events.size(), run_events[i]);
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic report_mismatch(string what, logic [31:0] expv, logic [31:0] gotv);
		$display("MISMATCH %s: expected 0x%0h, got 0x%0h (request %0d)",
			what, expv, gotv, requests_sent);
		mismatches++;
	endtask

	task automatic send_request(logic [1:0] op, bit lvl, logic [31:0] now);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, now, lvl};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		predict_request(op, lvl, now);
		requests_sent++;
	endtask

	task automatic stop_input();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for every predicted event, then lets a request with no event settle.
	task automatic wait_drained();
		int waited;
		waited = 0;
		while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_events.size() != 0) begin
			report_mismatch("events never delivered", 32'd0, pending_events.size());
			pending_events.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_registers(logic [15:0] hold, logic [15:0] win);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LONG_HOLD;
		cfg_wdata <= hold;
		@(posedge clk);
		cfg_hold_limit = hold;
		cfg_index <= REG_CLICK_WIN;
		cfg_wdata <= win;
		@(posedge clk);
		cfg_click_window = win;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [31:0] advance_time(int unsigned scale);
		if ($urandom_range(0, 19) == 0)
			cur_time = cur_time - $urandom_range(1, scale);
		else
			cur_time = cur_time + $urandom_range(0, scale);
		return cur_time;
	endfunction

	// Mostly well-formed press and release sequences with ticks, plus noise.
	task automatic run_random(int items, int unsigned scale);
		int unsigned pick;
		logic [1:0]  op;
		bit          lvl;
		logic [31:0] now;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 15) == 0)
				no_gaps = !no_gaps;
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				op  = 2'($urandom_range(0, 3));
				lvl = 1'($urandom_range(0, 1));
				now = $urandom();
				if (pick < 5)
					cur_time = now;
			end else if (pick < 14) begin
				op  = OP_CANCEL;
				lvl = 1'($urandom_range(0, 1));
				now = advance_time(scale);
			end else if (pick < 45) begin
				op  = OP_TICK;
				lvl = 1'($urandom_range(0, 1));
				now = advance_time(scale);
			end else begin
				op  = OP_LEVEL;
				lvl = (pick < 90) ? !st_pressed : st_pressed;
				now = advance_time(scale);
			end
			send_request(op, lvl, now);
			file_events();
		end
	endtask

	// ---------------------------------------------------------------- checker

	initial begin
		int          stall;
		click_evt_t  want;
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			events_seen++;
			if (pending_events.size() == 0) begin
				report_mismatch("unexpected event kind", 32'd0, 32'(m_axis_tuser));
			end else begin
				want = pending_events.pop_front();
				if (m_axis_tuser != want.kind)
					report_mismatch("event_kind", 32'(want.kind), 32'(m_axis_tuser));
				if (m_axis_tdata != want.stamp)
					report_mismatch("event_time", want.stamp, m_axis_tdata);
				if (m_axis_tlast != want.last)
					report_mismatch("last_of_run", 32'(want.last), 32'(m_axis_tlast));
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles", cycles);
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int unsigned scale;
		logic [15:0] hold;
		logic [15:0] win;
		click_evt_t  typed_ev;
		cfg_hold_limit   = LONG_HOLD_RST;
		cfg_click_window = CLICK_WIN_RST;
		clear_button_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset register values.
		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].op, directed_rows[i].lvl, directed_rows[i].now);
			if (directed_rows[i].typed) begin
				typed_ev.kind  = directed_rows[i].kind;
				typed_ev.stamp = directed_rows[i].stamp;
				typed_ev.last  = 1'b1;
				run_events.delete();
				run_events.insert(0, typed_ev);
			end
			file_events();
		end
		stop_input();
		wait_drained();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			hold = phase_hold[p];
			win  = phase_win[p];
			if (p == PHASE_COUNT - 1) begin
				hold = 16'($urandom_range(1, 2000));
				win  = 16'($urandom_range(1, 600));
			end
			set_registers(hold, win);
			scale = 2 * ((hold > win) ? hold : win) + 2;
			cur_time = (p == 3) ? 32'hFFFF_0000 : $urandom_range(0, 1 << 20);
			run_random(PHASE_ITEMS, scale);
			stop_input();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d requests and checked %0d events", requests_sent, events_seen);
		$display("across %0d register settings with random stalls on both streams.",
			settings_used);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
